// ===== hw/rtl/bsa_pkg.sv =====
// Shared types and constants for the banker's safe-allocation block.
// No dependencies; every other file in hw/rtl but bsa_row_mem refers to this package.
package bsa_pkg;

    // Default sizes
    localparam int DEF_NUM_PROCESSES = 8;
    localparam int DEF_NUM_RESOURCES = 4;

    // Field widths
    localparam int OP_W     = 2;
    localparam int PID_W    = 3;
    localparam int RID_W    = 2;
    localparam int UNIT_W   = 8;
    localparam int ALLOC_W  = 9;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 4;
    localparam int POS_W    = 3;

    // Allocation saturates at this value
    localparam logic [ALLOC_W-1:0] ALLOC_MAX = {ALLOC_W{1'b1}};

    // Operation codes; the fourth code is ignored
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_CELL = 2'd0,
        OP_SET_AVAIL = 2'd1,
        OP_REQUEST   = 2'd2
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANT  = 3'd0,
        ST_EXCEED = 3'd1,
        ST_WAIT   = 3'd2,
        ST_UNSAFE = 3'd3,
        ST_LOAD   = 3'd4
    } status_t;

    // Outcome of a safety walk, valid while finish is high
    typedef struct packed {
        logic               finish;
        logic               safe;
        logic [COUNT_W-1:0] count;
    } walk_result_t;

endpackage

// ===== hw/rtl/bsa_if.sv =====
// Valid/ready channel interfaces for the command and result streams.
// Depends on bsa_pkg for the field widths.
interface bsa_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [bsa_pkg::OP_W-1:0]   op;
    logic [bsa_pkg::PID_W-1:0]  proc_id;
    logic [bsa_pkg::RID_W-1:0]  res_id;
    logic [bsa_pkg::UNIT_W-1:0] first_value;
    logic [bsa_pkg::UNIT_W-1:0] second_value;
    logic [bsa_pkg::UNIT_W-1:0] req_0;
    logic [bsa_pkg::UNIT_W-1:0] req_1;
    logic [bsa_pkg::UNIT_W-1:0] req_2;
    logic [bsa_pkg::UNIT_W-1:0] req_3;

    modport source (
        output valid, op, proc_id, res_id, first_value, second_value,
               req_0, req_1, req_2, req_3,
        input  ready
    );
    modport sink (
        input  valid, op, proc_id, res_id, first_value, second_value,
               req_0, req_1, req_2, req_3,
        output ready
    );
endinterface

interface bsa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bsa_pkg::STATUS_W-1:0] status;
    logic [bsa_pkg::COUNT_W-1:0]  finished_count;
    logic [bsa_pkg::POS_W-1:0]    seq_position;
    logic [bsa_pkg::PID_W-1:0]    seq_process;
    logic                         last;

    modport source (
        output valid, status, finished_count, seq_position, seq_process, last,
        input  ready
    );
    modport sink (
        input  valid, status, finished_count, seq_position, seq_process, last,
        output ready
    );
endinterface

// ===== hw/rtl/bsa_row_mem.sv =====
// Per-process row memory: allocation and need of all resources in one word.
// Synchronous registered read; rows never written read as zero.
// Depends on no package.
module bsa_row_mem #(
    parameter int NUM_PROCESSES = 8,
    parameter int ROW_W         = 68
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [$clog2(NUM_PROCESSES)-1:0] wr_addr,
    input  logic [ROW_W-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(NUM_PROCESSES)-1:0] rd_addr,
    output logic [ROW_W-1:0]                 rd_data
);

    logic [ROW_W-1:0]         row_array [NUM_PROCESSES];
    logic [ROW_W-1:0]         rd_data_reg;
    logic [NUM_PROCESSES-1:0] row_valid_reg;
    logic                     rd_valid_reg;

    // Storage and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= row_array[rd_addr];
        end
    end

    // Row valid bits stand in for the zero reset of the matrices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hw/rtl/bsa_safety_walk.sv =====
// Safety walk engine: streams rows out of the row memory, one check a cycle,
// keeps the work vector, finished flags and the safe sequence.
// Depends on bsa_pkg.
module bsa_safety_walk #(
    parameter int NUM_PROCESSES = 8,
    parameter int NUM_RESOURCES = 4
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               start,
    input  logic [NUM_RESOURCES-1:0][bsa_pkg::UNIT_W-1:0]      init_avail,
    output logic                                               rd_en,
    output logic [$clog2(NUM_PROCESSES)-1:0]                   rd_addr,
    input  logic [NUM_RESOURCES*(bsa_pkg::UNIT_W+bsa_pkg::ALLOC_W)-1:0] rd_data,
    input  logic [$clog2(NUM_PROCESSES)-1:0]                   emit_idx,
    output logic [$clog2(NUM_PROCESSES)-1:0]                   emit_proc,
    output bsa_pkg::walk_result_t                              result
);

    localparam int IDX_W  = $clog2(NUM_PROCESSES);
    localparam int PTR_W  = $clog2(NUM_PROCESSES + 1);
    localparam int CNT_W  = $clog2(NUM_PROCESSES + 1);
    localparam int WORK_W = $clog2((1 << bsa_pkg::UNIT_W)
                                   + NUM_PROCESSES * (1 << bsa_pkg::ALLOC_W));

    logic [NUM_RESOURCES-1:0][bsa_pkg::UNIT_W-1:0]  rd_need;
    logic [NUM_RESOURCES-1:0][bsa_pkg::ALLOC_W-1:0] rd_alloc;

    logic [NUM_RESOURCES-1:0][WORK_W-1:0] work_reg, work_next;
    logic [NUM_PROCESSES-1:0]             done_reg, done_next;
    logic [NUM_PROCESSES-1:0][IDX_W-1:0]  order_reg, order_next;
    logic [CNT_W-1:0]                     count_reg, count_next;
    logic [PTR_W-1:0]                     issue_ptr_reg, issue_ptr_next;
    logic                                 chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]                     chk_idx_reg, chk_idx_next;
    logic                                 active_reg, active_next;

    logic             need_fits;
    logic             fits;
    logic             all_done;
    logic             exhausted;
    logic [CNT_W-1:0] count_inc;

    assign {rd_need, rd_alloc} = rd_data;

    // Row check against the work vector
    always_comb
    begin
        need_fits = 1'b1;
        for (int r = 0; r < NUM_RESOURCES; r++)
        begin
            if (WORK_W'(rd_need[r]) > work_reg[r])
            begin
                need_fits = 1'b0;
            end
        end
    end

    assign count_inc = count_reg + 1'b1;
    assign fits      = active_reg && chk_valid_reg && !done_reg[chk_idx_reg] && need_fits;
    assign all_done  = fits && (count_inc == CNT_W'(NUM_PROCESSES));
    assign exhausted = active_reg && chk_valid_reg && !fits
                       && (chk_idx_reg == IDX_W'(NUM_PROCESSES - 1));

    // A finish restarts the scan at row 0 in the same cycle
    assign rd_addr = fits ? '0 : issue_ptr_reg[IDX_W-1:0];
    assign rd_en   = active_reg && !all_done && !exhausted
                     && (fits || (issue_ptr_reg < PTR_W'(NUM_PROCESSES)));

    assign result.finish = all_done || exhausted;
    assign result.safe   = all_done;
    assign result.count  = bsa_pkg::COUNT_W'(fits ? count_inc : count_reg);
    assign emit_proc     = order_reg[emit_idx];

    // Next-state logic of the walk
    always_comb
    begin
        work_next      = work_reg;
        done_next      = done_reg;
        order_next     = order_reg;
        count_next     = count_reg;
        issue_ptr_next = issue_ptr_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        active_next    = active_reg;

        if (start)
        begin
            active_next    = 1'b1;
            done_next      = '0;
            count_next     = '0;
            issue_ptr_next = '0;
            chk_valid_next = 1'b0;
            for (int r = 0; r < NUM_RESOURCES; r++)
            begin
                work_next[r] = WORK_W'(init_avail[r]);
            end
        end
        else if (active_reg)
        begin
            if (all_done || exhausted)
            begin
                active_next    = 1'b0;
                chk_valid_next = 1'b0;
            end
            else
            begin
                chk_valid_next = rd_en;
                chk_idx_next   = rd_addr;
                if (rd_en)
                begin
                    issue_ptr_next = PTR_W'(rd_addr) + 1'b1;
                end
            end
            if (fits)
            begin
                for (int r = 0; r < NUM_RESOURCES; r++)
                begin
                    work_next[r] = work_reg[r] + WORK_W'(rd_alloc[r]);
                end
                done_next[chk_idx_reg]           = 1'b1;
                order_next[count_reg[IDX_W-1:0]] = chk_idx_reg;
                count_next                       = count_inc;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            chk_valid_reg <= 1'b0;
            issue_ptr_reg <= '0;
            count_reg     <= '0;
            done_reg      <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            chk_valid_reg <= chk_valid_next;
            issue_ptr_reg <= issue_ptr_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        order_reg   <= order_next;
        chk_idx_reg <= chk_idx_next;
    end

endmodule

// ===== hw/rtl/bsa_ctrl.sv =====
// Command sequencer: decodes commands, does read-modify-write on the row
// memory, checks requests, starts the walk, rolls back and drives results.
// Depends on bsa_pkg and the channel interfaces in bsa_if.sv.
module bsa_ctrl #(
    parameter int NUM_PROCESSES = 8,
    parameter int NUM_RESOURCES = 4
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    bsa_cmd_if.sink                                            cmd,
    bsa_rsp_if.source                                          rsp,
    // row memory port
    output logic                                               mem_wr_en,
    output logic [$clog2(NUM_PROCESSES)-1:0]                   mem_wr_addr,
    output logic [NUM_RESOURCES*(bsa_pkg::UNIT_W+bsa_pkg::ALLOC_W)-1:0] mem_wr_data,
    output logic                                               mem_rd_en,
    output logic [$clog2(NUM_PROCESSES)-1:0]                   mem_rd_addr,
    input  logic [NUM_RESOURCES*(bsa_pkg::UNIT_W+bsa_pkg::ALLOC_W)-1:0] mem_rd_data,
    // safety walk
    output logic                                               walk_start,
    output logic [NUM_RESOURCES-1:0][bsa_pkg::UNIT_W-1:0]      walk_avail,
    input  logic                                               walk_rd_en,
    input  logic [$clog2(NUM_PROCESSES)-1:0]                   walk_rd_addr,
    output logic [$clog2(NUM_PROCESSES)-1:0]                   emit_idx,
    input  logic [$clog2(NUM_PROCESSES)-1:0]                   emit_proc,
    input  bsa_pkg::walk_result_t                              walk_res
);

    localparam int IDX_W  = $clog2(NUM_PROCESSES);
    localparam int RIDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int ROW_W  = NUM_RESOURCES * (bsa_pkg::UNIT_W + bsa_pkg::ALLOC_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_RMW,
        S_REQ_CHECK,
        S_WALK,
        S_RESP,
        S_EMIT
    } state_t;

    typedef logic [NUM_RESOURCES-1:0][bsa_pkg::UNIT_W-1:0]  units_t;
    typedef logic [NUM_RESOURCES-1:0][bsa_pkg::ALLOC_W-1:0] allocs_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]           pid_reg, pid_next;
    logic [RIDX_W-1:0]          rid_reg, rid_next;
    logic [bsa_pkg::UNIT_W-1:0] v1_reg, v1_next;
    logic [bsa_pkg::UNIT_W-1:0] v2_reg, v2_next;
    units_t                     req_reg, req_next;
    units_t                     avail_reg, avail_next;
    units_t                     save_avail_reg, save_avail_next;
    logic [ROW_W-1:0]           save_row_reg, save_row_next;
    bsa_pkg::status_t           resp_status_reg, resp_status_next;
    logic [bsa_pkg::COUNT_W-1:0] resp_count_reg, resp_count_next;
    logic [IDX_W-1:0]           emit_idx_reg, emit_idx_next;

    logic                        out_valid_reg, out_valid_next;
    bsa_pkg::status_t            out_status_reg, out_status_next;
    logic [bsa_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic [bsa_pkg::POS_W-1:0]   out_pos_reg, out_pos_next;
    logic [bsa_pkg::PID_W-1:0]   out_proc_reg, out_proc_next;
    logic                        out_last_reg, out_last_next;

    units_t           cmd_req;
    units_t           rd_need;
    allocs_t          rd_alloc;
    units_t           tent_need;
    allocs_t          tent_alloc;
    units_t           tent_avail;
    units_t           load_need;
    allocs_t          load_alloc;
    logic             chk_fail;
    bsa_pkg::status_t chk_status;
    logic             accept;
    logic             slot_free;
    logic             pid_ok;
    logic             rid_ok;
    logic             ctrl_rd_en;

    // Request fields beyond the resource count are dropped here
    always_comb
    begin
        logic [3:0][bsa_pkg::UNIT_W-1:0] all_req;
        all_req = {cmd.req_3, cmd.req_2, cmd.req_1, cmd.req_0};
        for (int r = 0; r < NUM_RESOURCES; r++)
        begin
            cmd_req[r] = all_req[r];
        end
    end

    assign {rd_need, rd_alloc} = mem_rd_data;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign pid_ok    = {1'b0, cmd.proc_id} < (bsa_pkg::PID_W + 1)'(NUM_PROCESSES);
    assign rid_ok    = {1'b0, cmd.res_id} < (bsa_pkg::RID_W + 1)'(NUM_RESOURCES);

    // Request check in ascending resource order, plus the tentative row
    always_comb
    begin
        logic [bsa_pkg::ALLOC_W:0] sum;
        chk_fail   = 1'b0;
        chk_status = bsa_pkg::ST_GRANT;
        sum        = '0;
        for (int r = 0; r < NUM_RESOURCES; r++)
        begin
            if (!chk_fail)
            begin
                if (req_reg[r] > rd_need[r])
                begin
                    chk_fail   = 1'b1;
                    chk_status = bsa_pkg::ST_EXCEED;
                end
                else if (req_reg[r] > avail_reg[r])
                begin
                    chk_fail   = 1'b1;
                    chk_status = bsa_pkg::ST_WAIT;
                end
            end
            sum           = {1'b0, rd_alloc[r]} + (bsa_pkg::ALLOC_W + 1)'(req_reg[r]);
            tent_alloc[r] = sum[bsa_pkg::ALLOC_W] ? bsa_pkg::ALLOC_MAX
                                                  : sum[bsa_pkg::ALLOC_W-1:0];
            tent_need[r]  = rd_need[r] - req_reg[r];
            tent_avail[r] = avail_reg[r] - req_reg[r];
        end
    end

    // Single-cell update of a row for a load command
    always_comb
    begin
        load_need           = rd_need;
        load_alloc          = rd_alloc;
        load_need[rid_reg]  = v2_reg;
        load_alloc[rid_reg] = bsa_pkg::ALLOC_W'(v1_reg);
    end

    // Memory read port shared between the sequencer and the walk
    assign mem_rd_en   = ctrl_rd_en || ((state_reg == S_WALK) && walk_rd_en);
    assign mem_rd_addr = (state_reg == S_WALK) ? walk_rd_addr : cmd.proc_id[IDX_W-1:0];
    assign walk_avail  = tent_avail;
    assign emit_idx    = emit_idx_reg;

    // Sequencer next-state logic
    always_comb
    begin
        state_next       = state_reg;
        pid_next         = pid_reg;
        rid_next         = rid_reg;
        v1_next          = v1_reg;
        v2_next          = v2_reg;
        req_next         = req_reg;
        avail_next       = avail_reg;
        save_avail_next  = save_avail_reg;
        save_row_next    = save_row_reg;
        resp_status_next = resp_status_reg;
        resp_count_next  = resp_count_reg;
        emit_idx_next    = emit_idx_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        out_pos_next     = out_pos_reg;
        out_proc_next    = out_proc_reg;
        out_last_next    = out_last_reg;
        ctrl_rd_en       = 1'b0;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = pid_reg;
        mem_wr_data      = {load_need, load_alloc};
        walk_start       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pid_next         = cmd.proc_id[IDX_W-1:0];
                    rid_next         = cmd.res_id[RIDX_W-1:0];
                    v1_next          = cmd.first_value;
                    v2_next          = cmd.second_value;
                    req_next         = cmd_req;
                    resp_count_next  = '0;
                    resp_status_next = bsa_pkg::ST_LOAD;
                    unique case (cmd.op)
                        bsa_pkg::OP_LOAD_CELL:
                        begin
                            if (pid_ok && rid_ok)
                            begin
                                ctrl_rd_en = 1'b1;
                                state_next = S_LOAD_RMW;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        bsa_pkg::OP_SET_AVAIL:
                        begin
                            if (rid_ok)
                            begin
                                avail_next[cmd.res_id[RIDX_W-1:0]] = cmd.first_value;
                            end
                            state_next = S_RESP;
                        end
                        bsa_pkg::OP_REQUEST:
                        begin
                            if (pid_ok)
                            begin
                                ctrl_rd_en = 1'b1;
                                state_next = S_REQ_CHECK;
                            end
                            else
                            begin
                                resp_status_next = bsa_pkg::ST_EXCEED;
                                state_next       = S_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_LOAD_RMW:
            begin
                mem_wr_en  = 1'b1;
                state_next = S_RESP;
            end

            S_REQ_CHECK:
            begin
                if (chk_fail)
                begin
                    resp_status_next = chk_status;
                    state_next       = S_RESP;
                end
                else
                begin
                    // apply tentatively, keep the old values for rollback
                    mem_wr_en       = 1'b1;
                    mem_wr_data     = {tent_need, tent_alloc};
                    save_row_next   = mem_rd_data;
                    save_avail_next = avail_reg;
                    avail_next      = tent_avail;
                    walk_start      = 1'b1;
                    state_next      = S_WALK;
                end
            end

            S_WALK:
            begin
                if (walk_res.finish)
                begin
                    if (walk_res.safe)
                    begin
                        emit_idx_next = '0;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        mem_wr_en        = 1'b1;
                        mem_wr_data      = save_row_reg;
                        avail_next       = save_avail_reg;
                        resp_status_next = bsa_pkg::ST_UNSAFE;
                        resp_count_next  = walk_res.count;
                        state_next       = S_RESP;
                    end
                end
            end

            S_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = resp_status_reg;
                    out_count_next  = resp_count_reg;
                    out_pos_next    = '0;
                    out_proc_next   = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = bsa_pkg::ST_GRANT;
                    out_count_next  = bsa_pkg::COUNT_W'(NUM_PROCESSES);
                    out_pos_next    = bsa_pkg::POS_W'(emit_idx_reg);
                    out_proc_next   = bsa_pkg::PID_W'(emit_proc);
                    out_last_next   = (emit_idx_reg == IDX_W'(NUM_PROCESSES - 1));
                    emit_idx_next   = emit_idx_reg + 1'b1;
                    if (emit_idx_reg == IDX_W'(NUM_PROCESSES - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            avail_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= bsa_pkg::ST_GRANT;
            out_count_reg  <= '0;
            out_pos_reg    <= '0;
            out_proc_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            avail_reg      <= avail_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
            out_pos_reg    <= out_pos_next;
            out_proc_reg   <= out_proc_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pid_reg         <= pid_next;
        rid_reg         <= rid_next;
        v1_reg          <= v1_next;
        v2_reg          <= v2_next;
        req_reg         <= req_next;
        save_avail_reg  <= save_avail_next;
        save_row_reg    <= save_row_next;
        resp_status_reg <= resp_status_next;
        resp_count_reg  <= resp_count_next;
        emit_idx_reg    <= emit_idx_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.finished_count = out_count_reg;
    assign rsp.seq_position   = out_pos_reg;
    assign rsp.seq_process    = out_proc_reg;
    assign rsp.last           = out_last_reg;

endmodule

// ===== hw/rtl/banker_safe_allocation.sv =====
// Channel    Role    Payload
// cmd        sink    op, proc_id, res_id, first_value, second_value, req_0..req_3
// rsp        source  status, finished_count, seq_position, seq_process, last
//
// cmd.ready is high only while idle. A cell load steps through accept, row
// read-modify-write and result, an available load through accept and result;
// the result is valid the cycle after. A request first reads and checks its
// row; a walk then reads its first row and does one row check per cycle, at
// most NUM_PROCESSES*(NUM_PROCESSES+3)/2-1 checks (43 for 8 processes), then
// gives NUM_PROCESSES results when granted, one otherwise. Reset clears the
// available vector and the row valid bits at once; there is no clearing pass.
// A stalled result holds in the output register; one new request is taken
// while it waits.
// Depends on bsa_pkg, bsa_if, bsa_row_mem, bsa_safety_walk and bsa_ctrl.
module banker_safe_allocation #(
    parameter int NUM_PROCESSES = bsa_pkg::DEF_NUM_PROCESSES,
    parameter int NUM_RESOURCES = bsa_pkg::DEF_NUM_RESOURCES
) (
    input  logic      clk,
    input  logic      rst_n,
    bsa_cmd_if.sink   cmd,
    bsa_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(NUM_PROCESSES);
    localparam int ROW_W = NUM_RESOURCES * (bsa_pkg::UNIT_W + bsa_pkg::ALLOC_W);

    logic                                          mem_wr_en;
    logic [IDX_W-1:0]                              mem_wr_addr;
    logic [ROW_W-1:0]                              mem_wr_data;
    logic                                          mem_rd_en;
    logic [IDX_W-1:0]                              mem_rd_addr;
    logic [ROW_W-1:0]                              mem_rd_data;
    logic                                          walk_start;
    logic [NUM_RESOURCES-1:0][bsa_pkg::UNIT_W-1:0] walk_avail;
    logic                                          walk_rd_en;
    logic [IDX_W-1:0]                              walk_rd_addr;
    logic [IDX_W-1:0]                              emit_idx;
    logic [IDX_W-1:0]                              emit_proc;
    bsa_pkg::walk_result_t                         walk_res;

    // Allocation and need rows
    bsa_row_mem #(
        .NUM_PROCESSES (NUM_PROCESSES),
        .ROW_W         (ROW_W)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Safety walk engine
    bsa_safety_walk #(
        .NUM_PROCESSES (NUM_PROCESSES),
        .NUM_RESOURCES (NUM_RESOURCES)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (walk_start),
        .init_avail (walk_avail),
        .rd_en      (walk_rd_en),
        .rd_addr    (walk_rd_addr),
        .rd_data    (mem_rd_data),
        .emit_idx   (emit_idx),
        .emit_proc  (emit_proc),
        .result     (walk_res)
    );

    // Command sequencer and result register
    bsa_ctrl #(
        .NUM_PROCESSES (NUM_PROCESSES),
        .NUM_RESOURCES (NUM_RESOURCES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rsp          (rsp),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data),
        .walk_start   (walk_start),
        .walk_avail   (walk_avail),
        .walk_rd_en   (walk_rd_en),
        .walk_rd_addr (walk_rd_addr),
        .emit_idx     (emit_idx),
        .emit_proc    (emit_proc),
        .walk_res     (walk_res)
    );

endmodule
